// ----- hdl/point_to_polyline_min_distance_defines.svh -----
// Assertion macros for the point to polyline block
`ifndef POINT_TO_POLYLINE_MIN_DISTANCE_DEFINES_SVH
`define POINT_TO_POLYLINE_MIN_DISTANCE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PTPD_ASSERT_IMP(lbl, clk, rstn, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);
`define PTPD_ASSERT_NXT(lbl, clk, rstn, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`else
`define PTPD_ASSERT_IMP(lbl, clk, rstn, a, b, msg)
`define PTPD_ASSERT_NXT(lbl, clk, rstn, a, b, msg)
`endif

`endif

// ----- hdl/ptpd_pkg.sv -----
package ptpd_pkg;
	localparam int DEF_COORD_WIDTH = 32;
	localparam int DIST_W = 48;
	localparam int SCALE_W = 24;
	localparam int IDX_W = 2;
	localparam logic [DIST_W-1:0] MAX48 = {DIST_W{1'b1}};
	localparam logic [IDX_W-1:0] REG_SCALE_EN = 2'd0;
	localparam logic [IDX_W-1:0] REG_LNG_SCALE = 2'd1;
	localparam logic [IDX_W-1:0] REG_LAT_SCALE = 2'd2;
	localparam logic [SCALE_W-1:0] LNG_SCALE_RST = 24'd5640683;
	localparam logic [SCALE_W-1:0] LAT_SCALE_RST = 24'd7287268;
endpackage

// ----- hdl/ptpd_mul.sv -----
module ptpd_mul import ptpd_pkg::*; #(
	parameter int WIDTH = DEF_COORD_WIDTH + 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [WIDTH-1:0]   a,
	input  logic [WIDTH-1:0]   b,
	output logic               done,
	output logic [2*WIDTH-1:0] p
);
	localparam int CW = $clog2(WIDTH);
	logic [2*WIDTH-1:0] p_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [WIDTH:0] sum;

	assign sum = {1'b0, p_q[2*WIDTH-1:WIDTH]} + (p_q[0] ? {1'b0, a} : {(WIDTH+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WIDTH-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= {{WIDTH{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[WIDTH-1:1]};
		end
	end

	assign done = done_q;
	assign p = p_q;
endmodule

// ----- hdl/ptpd_sqrt.sv -----
module ptpd_sqrt import ptpd_pkg::*; #(
	parameter int NW = 2 * DEF_COORD_WIDTH + 18
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NW-1:0]   n,
	output logic            done,
	output logic [NW/2-1:0] root
);
	localparam int HW = NW / 2;
	localparam int CW = $clog2(HW);
	logic [NW-1:0] n_q;
	logic [HW+1:0] rem_q, rs, trial;
	logic [HW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q, fit;

	assign rs = {rem_q[HW-1:0], n_q[NW-1:NW-2]};
	assign trial = {root_q, 2'b01};
	assign fit = rs >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(HW-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NW-3:0], 2'b00};
			rem_q <= fit ? (rs - trial) : rs;
			root_q <= {root_q[HW-2:0], fit};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ----- hdl/ptpd_div.sv -----
module ptpd_div import ptpd_pkg::*; #(
	parameter int NW = 2 * DEF_COORD_WIDTH + 17,
	parameter int DW = DEF_COORD_WIDTH + 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW);
	logic [NW-1:0] q_q;
	logic [DW-1:0] rem_q, den_q;
	logic [DW:0] rs, diff;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q, fit;

	assign rs = {rem_q, q_q[NW-1]};
	assign diff = rs - {1'b0, den_q};
	assign fit = rs >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fit ? diff[DW-1:0] : rs[DW-1:0];
			q_q <= {q_q[NW-2:0], fit};
		end
	end

	assign done = done_q;
	assign quo = q_q;
endmodule

// ----- hdl/point_to_polyline_min_distance.sv -----
// channel   | group            | fields (lsb first)
// ----------+------------------+-------------------------------------------------
// input     | s_tvalid/tready  | tdata: point_x, point_y, vertex_x, vertex_y
//           |                  | tuser: first_vertex, last_vertex
// output    | m_tvalid/tready  | tdata: min_distance; tuser: no_segment
// config    | wr_en            | wr_index, wr_data
//
// A first-vertex request stores the vertex and restarts the running minimum. A
// segment request runs one shared bit-serial multiplier (6 scaling passes when
// scale_enable, then 10 product passes), a 2-bit-per-cycle square root (2 or 3
// passes) and a 1-bit-per-cycle divider (inside the segment only).
// Reset is asynchronous, active low. A result waits in the output register; a
// new request is taken meanwhile, and a final vertex holds only until the output
// register is free.
module point_to_polyline_min_distance import ptpd_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// point_x, point_y, vertex_x, vertex_y
	input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	// first_vertex, last_vertex
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// min_distance
	output logic [DIST_W-1:0] m_tdata,
	// no_segment
	output logic [0:0] m_tuser,
	input  logic wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [SCALE_W-1:0] wr_data
);
	localparam int W = COORD_WIDTH;
	localparam int DW = W + 1;
	localparam int MW = W + 8;
	localparam int PW = 2 * MW;
	localparam int SW = PW + 1;
	localparam int AW = PW + 2;
	localparam int RW = MW + 1;
	localparam int XW = (RW > DIST_W) ? RW : DIST_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIFF = 4'd1;
	localparam logic [3:0] ST_SMUL = 4'd2;
	localparam logic [3:0] ST_PMUL = 4'd3;
	localparam logic [3:0] ST_PWAIT = 4'd4;
	localparam logic [3:0] ST_TEST = 4'd5;
	localparam logic [3:0] ST_SQRT = 4'd6;
	localparam logic [3:0] ST_SWAIT = 4'd7;
	localparam logic [3:0] ST_DIVS = 4'd8;
	localparam logic [3:0] ST_DIVW = 4'd9;
	localparam logic [3:0] ST_UPD = 4'd10;
	localparam logic [3:0] ST_FIN = 4'd11;

	logic [3:0] state_q;
	logic scale_en_q;
	logic [SCALE_W-1:0] lng_q, lat_q;
	logic signed [W-1:0] px_q, py_q, vx_q, vy_q, prev_x_q, prev_y_q;
	logic last_q;
	logic [DIST_W-1:0] best_q, da_q, dc_q, perp_q;
	logic seen_q, inside_q;
	logic [2:0] k_q;
	logic [3:0] pidx_q;
	logic [MW-1:0] axm_q, aym_q, bxm_q, bym_q, cxm_q, cym_q;
	logic axs_q, ays_q, bxs_q, bys_q;
	logic signed [AW-1:0] acc_q, dot_q, cr_q;
	logic [SW-1:0] da2_q, dc2_q, len2_q;
	logic [RW-1:0] len_q;
	logic m_tvalid_q;
	logic [DIST_W-1:0] m_tdata_q;
	logic m_tuser_q;

	logic signed [W-1:0] opa, opb;
	logic [DW-1:0] dsub, dmag;
	logic dneg;
	logic [SCALE_W-1:0] sc;
	logic [MW-1:0] cur_mag, pa, pb;
	logic cur_sgn, ps;
	logic mul_start, mul_done;
	logic [MW-1:0] mul_a, mul_b;
	logic [PW-1:0] mul_p, rnd;
	logic [AW-1:0] pe, term, psum;
	logic sq_start, sq_done;
	logic [SW:0] sq_n;
	logic [RW-1:0] sq_root;
	logic [XW-1:0] root_x;
	logic [DIST_W-1:0] root_sat, quo_sat, dmin, dseg;
	logic div_start, div_done;
	logic [SW-1:0] div_quo, crm;
	logic [AW-1:0] crabs;
	logic [AW:0] gap;
	logic dot_pos, gap_pos, out_free;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_en_q <= 1'b1;
			lng_q <= LNG_SCALE_RST;
			lat_q <= LAT_SCALE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_SCALE_EN: scale_en_q <= wr_data[0];
				REG_LNG_SCALE: lng_q <= wr_data;
				REG_LAT_SCALE: lat_q <= wr_data;
				default: ;
			endcase
		end
	end

	// coordinate differences, one per cycle when scaling is off; with scaling each waits for its multiplier pass
	always_comb begin
		case (k_q)
			3'd0: begin opa = px_q; opb = prev_x_q; end
			3'd1: begin opa = py_q; opb = prev_y_q; end
			3'd2: begin opa = vx_q; opb = prev_x_q; end
			3'd3: begin opa = vy_q; opb = prev_y_q; end
			3'd4: begin opa = px_q; opb = vx_q; end
			default: begin opa = py_q; opb = vy_q; end
		endcase
		sc = k_q[0] ? lat_q : lng_q;
	end
	assign dsub = {opa[W-1], opa} - {opb[W-1], opb};
	assign dneg = dsub[DW-1];
	assign dmag = dneg ? (~dsub + 1'b1) : dsub;
	assign rnd = mul_p + PW'(32768);
	assign cur_mag = (state_q == ST_SMUL) ? rnd[MW+15:16] : {{(MW-DW){1'b0}}, dmag};
	assign cur_sgn = dneg;

	// product operands
	always_comb begin
		case (pidx_q)
			4'd0: begin pa = axm_q; pb = axm_q; ps = 1'b0; end
			4'd1: begin pa = aym_q; pb = aym_q; ps = 1'b0; end
			4'd2: begin pa = cxm_q; pb = cxm_q; ps = 1'b0; end
			4'd3: begin pa = cym_q; pb = cym_q; ps = 1'b0; end
			4'd4: begin pa = axm_q; pb = bxm_q; ps = axs_q ^ bxs_q; end
			4'd5: begin pa = aym_q; pb = bym_q; ps = ays_q ^ bys_q; end
			4'd6: begin pa = bxm_q; pb = bxm_q; ps = 1'b0; end
			4'd7: begin pa = bym_q; pb = bym_q; ps = 1'b0; end
			4'd8: begin pa = bxm_q; pb = aym_q; ps = bxs_q ^ ays_q; end
			default: begin pa = bym_q; pb = axm_q; ps = ~(bys_q ^ axs_q); end
		endcase
	end

	assign mul_start = ((state_q == ST_DIFF) && scale_en_q) || (state_q == ST_PMUL);
	assign mul_a = (state_q == ST_PMUL || state_q == ST_PWAIT) ? pa :
		{{(MW-DW){1'b0}}, dmag};
	assign mul_b = (state_q == ST_PMUL) ? pb : {{(MW-SCALE_W){1'b0}}, sc};

	assign pe = {{(AW-PW){1'b0}}, mul_p};
	assign term = ps ? (~pe + 1'b1) : pe;
	assign psum = acc_q + term;

	assign dot_pos = !dot_q[AW-1] && (dot_q != '0);
	assign gap = $signed({2'b00, len2_q}) - $signed({dot_q[AW-1], dot_q});
	assign gap_pos = !gap[AW] && (gap != '0);

	always_comb begin
		case (k_q)
			3'd0: sq_n = {1'b0, da2_q};
			3'd1: sq_n = {1'b0, dc2_q};
			default: sq_n = {1'b0, len2_q};
		endcase
	end
	assign sq_start = (state_q == ST_SQRT);
	assign root_x = XW'(sq_root);
	assign root_sat = (root_x > XW'(MAX48)) ? MAX48 : root_x[DIST_W-1:0];

	assign crabs = cr_q[AW-1] ? (~cr_q + 1'b1) : cr_q;
	assign crm = crabs[SW-1:0];
	assign div_start = (state_q == ST_DIVS) && (len_q != '0);
	assign quo_sat = (div_quo > SW'(MAX48)) ? MAX48 : div_quo[DIST_W-1:0];

	assign dmin = (da_q <= dc_q) ? da_q : dc_q;
	assign dseg = (inside_q && (perp_q < dmin)) ? perp_q : dmin;
	assign out_free = !m_tvalid_q || m_tready;

	ptpd_mul #(.WIDTH(MW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);

	ptpd_sqrt #(.NW(SW + 1)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .n(sq_n),
		.done(sq_done), .root(sq_root)
	);

	ptpd_div #(.NW(SW), .DW(RW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(crm), .den(len_q),
		.done(div_done), .quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_x_q <= '0;
			prev_y_q <= '0;
			best_q <= MAX48;
			seen_q <= 1'b0;
			k_q <= '0;
			pidx_q <= '0;
			last_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						last_q <= s_tuser[1];
						k_q <= '0;
						if (s_tuser[0]) begin
							best_q <= MAX48;
							seen_q <= 1'b0;
							prev_x_q <= s_tdata[3*W-1:2*W];
							prev_y_q <= s_tdata[4*W-1:3*W];
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_DIFF;
						end
					end
				end
				ST_DIFF, ST_SMUL: begin
					if ((state_q == ST_DIFF && !scale_en_q) || (state_q == ST_SMUL && mul_done)) begin
						if (k_q == 3'd5) begin
							pidx_q <= '0;
							state_q <= ST_PMUL;
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= ST_DIFF;
						end
					end else if (state_q == ST_DIFF) begin
						state_q <= ST_SMUL;
					end
				end
				ST_PMUL: state_q <= ST_PWAIT;
				ST_PWAIT: begin
					if (mul_done) begin
						if (pidx_q == 4'd9) begin
							state_q <= ST_TEST;
						end else begin
							pidx_q <= pidx_q + 1'b1;
							state_q <= ST_PMUL;
						end
					end
				end
				ST_TEST: begin
					k_q <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: state_q <= ST_SWAIT;
				ST_SWAIT: begin
					if (sq_done) begin
						if (k_q == 3'd2) begin
							state_q <= ST_DIVS;
						end else if (k_q == 3'd1 && !inside_q) begin
							state_q <= ST_UPD;
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= ST_SQRT;
						end
					end
				end
				ST_DIVS: state_q <= (len_q == '0) ? ST_UPD : ST_DIVW;
				ST_DIVW: begin
					if (div_done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (dseg < best_q) begin
						best_q <= dseg;
					end
					seen_q <= 1'b1;
					prev_x_q <= vx_q;
					prev_y_q <= vy_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						best_q <= MAX48;
						seen_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_FIN && last_q && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			px_q <= s_tdata[W-1:0];
			py_q <= s_tdata[2*W-1:W];
			vx_q <= s_tdata[3*W-1:2*W];
			vy_q <= s_tdata[4*W-1:3*W];
		end
		if ((state_q == ST_DIFF && !scale_en_q) || (state_q == ST_SMUL && mul_done)) begin
			case (k_q)
				3'd0: begin axm_q <= cur_mag; axs_q <= cur_sgn; end
				3'd1: begin aym_q <= cur_mag; ays_q <= cur_sgn; end
				3'd2: begin bxm_q <= cur_mag; bxs_q <= cur_sgn; end
				3'd3: begin bym_q <= cur_mag; bys_q <= cur_sgn; end
				3'd4: cxm_q <= cur_mag;
				default: cym_q <= cur_mag;
			endcase
		end
		if (state_q == ST_PWAIT && mul_done) begin
			if (!pidx_q[0]) begin
				acc_q <= term;
			end else begin
				case (pidx_q)
					4'd1: da2_q <= psum[SW-1:0];
					4'd3: dc2_q <= psum[SW-1:0];
					4'd5: dot_q <= psum;
					4'd7: len2_q <= psum[SW-1:0];
					default: cr_q <= psum;
				endcase
			end
		end
		if (state_q == ST_TEST) begin
			inside_q <= dot_pos && gap_pos;
		end
		if (state_q == ST_SWAIT && sq_done) begin
			case (k_q)
				3'd0: da_q <= root_sat;
				3'd1: dc_q <= root_sat;
				default: len_q <= sq_root;
			endcase
		end
		if (state_q == ST_DIVS && len_q == '0) begin
			perp_q <= MAX48;
		end
		if (state_q == ST_DIVW && div_done) begin
			perp_q <= quo_sat;
		end
		if (state_q == ST_FIN && last_q && out_free) begin
			m_tdata_q <= seen_q ? best_q : MAX48;
			m_tuser_q <= !seen_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

`include "point_to_polyline_min_distance_defines.svh"

	`PTPD_ASSERT_IMP(a_noseg_max, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == MAX48, "no_segment result without all-ones distance")
	`PTPD_ASSERT_NXT(a_hold_fin, clk, arst_n, state_q == ST_FIN && last_q && m_tvalid && !m_tready, state_q == ST_FIN, "pending result overwritten")
	`PTPD_ASSERT_IMP(a_sq_state, clk, arst_n, sq_done, state_q == ST_SWAIT, "root finished outside its wait state")
endmodule
